FILE: sv/ipt_pkg.sv
// Package with the shared types, port keys, register indexes and timing tables.
`default_nettype none
package ipt_pkg;

  typedef logic [3:0] speed_t;

  // Speeds of all four drives as one snapshot, drive 0 in the lowest bits.
  typedef struct packed {
    speed_t [3:0] spd;
  } speed_set_t;

  // One port write as it leaves the block.
  typedef struct packed {
    logic       last;
    logic       to_data;
    logic [7:0] val;
  } port_wr_t;

  localparam logic [7:0] KeyUnlock = 8'h5A;
  localparam logic [7:0] KeyLock   = 8'hA5;
  localparam logic [7:0] RegNibHi  = 8'hD7;
  localparam logic [7:0] RegNibLo  = 8'hD6;
  localparam logic [7:0] RegPacked = 8'hDC;
  localparam logic [7:0] RegByteA  = 8'hD0;
  localparam logic [7:0] RegByteB  = 8'hD8;

  localparam logic [7:0] PioAuto  = 8'd255;
  localparam logic [7:0] PioMax   = 8'd4;
  localparam speed_t     SpeedMax = 4'd11;
  localparam speed_t     SpeedRst = 4'd1;

  localparam int unsigned NumWrites = 24;
  localparam int unsigned StepW     = $clog2(NumWrites);

  function automatic speed_t mode_to_speed(input logic [2:0] mode);
    speed_t r;
    case (mode)
      3'd0:    r = 4'd0;
      3'd1:    r = 4'd3;
      3'd2:    r = 4'd6;
      3'd3:    r = 4'd10;
      default: r = 4'd11;
    endcase
    return r;
  endfunction

  // Speeds above eleven read as eleven in all three timing tables.
  function automatic logic [3:0] nib_of(input speed_t s);
    logic [3:0] r;
    case (s)
      4'd0:                r = 4'hF;
      4'd1:                r = 4'hB;
      4'd2, 4'd3, 4'd4:    r = 4'h2;
      default:             r = 4'h1;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] two_of(input speed_t s);
    logic [1:0] r;
    case (s)
      4'd0:                      r = 2'h3;
      4'd1, 4'd2, 4'd3, 4'd4,
      4'd5:                      r = 2'h2;
      default:                   r = 2'h1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] byte_of(input speed_t s);
    logic [7:0] r;
    case (s)
      4'd0:    r = 8'hFF;
      4'd1:    r = 8'hCB;
      4'd2:    r = 8'hC0;
      4'd3:    r = 8'h58;
      4'd4:    r = 8'h36;
      4'd5:    r = 8'h33;
      4'd6:    r = 8'h23;
      4'd7:    r = 8'h22;
      4'd8:    r = 8'h21;
      4'd9:    r = 8'h11;
      4'd10:   r = 8'h10;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/ide_pio_timing_programmer_core.sv
// Top level of the IDE PIO timing programmer: request input and port-write stream.
`default_nettype none
// Each request (tune one drive, or reprogram the current speeds) produces a
// fixed run of 24 index/data port writes, one per cycle while the output is
// not stalled, ending with the lock key marked by tlast. The first write
// passes through the input register, the sequencer's snapshot and step
// registers and the output register. One further request
// is taken and held in the input register while a run is still streaming.
// Drive speeds reset to index 1 and are updated in request order.
module ide_pio_timing_programmer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] drive, [9:2] requested_pio, [17:10] ident_pio, [18] eide_valid,
  // [20:19] eide_modes, [23:21] zero
  input  wire logic [23:0] s_axis_tdata,
  // [0] func
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] byte_value
  output logic [7:0]       m_axis_tdata,
  // [0] to_data_port
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  logic                snap_valid;
  logic                snap_ready;
  ipt_pkg::speed_set_t snap;
  ipt_pkg::port_wr_t   wr;

  ipt_tune u_tune (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (s_axis_tvalid),
    .req_ready_o     (s_axis_tready),
    .func_i          (s_axis_tuser),
    .drive_i         (s_axis_tdata[1:0]),
    .requested_pio_i (s_axis_tdata[9:2]),
    .ident_pio_i     (s_axis_tdata[17:10]),
    .eide_valid_i    (s_axis_tdata[18]),
    .eide_modes_i    (s_axis_tdata[20:19]),
    .snap_valid_o    (snap_valid),
    .snap_ready_i    (snap_ready),
    .snap_o          (snap)
  );

  ipt_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (wr)
  );

  assign m_axis_tdata = wr.val;
  assign m_axis_tuser = wr.to_data;
  assign m_axis_tlast = wr.last;

endmodule
`default_nettype wire

FILE: sv/ipt_tune.sv
// Input register, PIO mode selection and the per-drive speed registers.
`default_nettype none
module ipt_tune (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire logic               func_i,
  input  wire logic [1:0]         drive_i,
  input  wire logic [7:0]         requested_pio_i,
  input  wire logic [7:0]         ident_pio_i,
  input  wire logic               eide_valid_i,
  input  wire logic [1:0]         eide_modes_i,
  output logic                    snap_valid_o,
  input  wire logic               snap_ready_i,
  output ipt_pkg::speed_set_t     snap_o
);

  logic       in_valid_q, in_valid_d;
  logic       func_q;
  logic [1:0] drive_q;
  logic [7:0] req_pio_q;
  logic [7:0] ident_pio_q;
  logic       eide_valid_q;
  logic [1:0] eide_modes_q;

  ipt_pkg::speed_set_t speed_q, speed_d;
  logic                fire;
  logic                take;
  logic [7:0]          mode;

  assign fire        = in_valid_q && snap_ready_i;
  assign req_ready_o = !in_valid_q || fire;
  assign take        = req_valid_i && req_ready_o;
  assign in_valid_d  = take ? 1'b1 : (fire ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      func_q       <= func_i;
      drive_q      <= drive_i;
      req_pio_q    <= requested_pio_i;
      ident_pio_q  <= ident_pio_i;
      eide_valid_q <= eide_valid_i;
      eide_modes_q <= eide_modes_i;
    end
  end

  // Auto-select takes the identify value, replaced by 3 or 4 by valid extended mode bits; clamped to PioMax.
  always_comb begin
    mode = req_pio_q;
    if (req_pio_q == ipt_pkg::PioAuto) begin
      mode = ident_pio_q;
      if (eide_valid_q) begin
        if (eide_modes_q[0]) mode = 8'd3;
        if (eide_modes_q[1]) mode = 8'd4;
      end
    end
    if (mode > ipt_pkg::PioMax) mode = ipt_pkg::PioMax;
  end

  always_comb begin
    speed_d = speed_q;
    if (!func_q) begin
      speed_d.spd[drive_q] = ipt_pkg::mode_to_speed(mode[2:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= {4{ipt_pkg::SpeedRst}};
    end else if (fire) begin
      speed_q <= speed_d;
    end
  end

  assign snap_valid_o = in_valid_q;
  assign snap_o       = speed_d;

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_q.spd[0] <= ipt_pkg::SpeedMax && speed_q.spd[1] <= ipt_pkg::SpeedMax &&
    speed_q.spd[2] <= ipt_pkg::SpeedMax && speed_q.spd[3] <= ipt_pkg::SpeedMax)
    else $error("drive speed out of range");

  a_speed_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(speed_q))
    else $error("drive speeds changed without a request");

endmodule
`default_nettype wire

FILE: sv/ipt_seq.sv
// Write sequencer: steps through the 24 port writes from a speed snapshot.
`default_nettype none
module ipt_seq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 snap_valid_i,
  output logic                      snap_ready_o,
  input  wire ipt_pkg::speed_set_t  snap_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ipt_pkg::port_wr_t         out_o
);

  localparam logic [ipt_pkg::StepW-1:0] LastStep = ipt_pkg::StepW'(ipt_pkg::NumWrites - 1);
  localparam logic [ipt_pkg::StepW-1:0] FirstByte = ipt_pkg::StepW'(7);

  logic                      busy_q, busy_d;
  logic [ipt_pkg::StepW-1:0] step_q, step_d;
  ipt_pkg::speed_set_t       snap_q;
  logic                      out_valid_q, out_valid_d;
  ipt_pkg::port_wr_t         out_q, wr;
  logic                      out_load;
  logic                      snap_load;
  logic [ipt_pkg::StepW-1:0] off;
  logic [1:0]                drv;

  assign out_load     = busy_q && (!out_valid_q || out_ready_i);
  assign snap_ready_o = !busy_q || (out_load && step_q == LastStep);
  assign snap_load    = snap_valid_i && snap_ready_o;

  // Steps seven to 22 are four per drive: index A, data, index B, data.
  assign off = step_q - FirstByte;
  assign drv = off[3:2];

  always_comb begin
    wr = '0;
    case (step_q)
      5'd0: wr.val = ipt_pkg::KeyUnlock;
      5'd1: wr.val = ipt_pkg::RegNibHi;
      5'd2: begin
        wr.to_data = 1'b1;
        wr.val     = {ipt_pkg::nib_of(snap_q.spd[3]), ipt_pkg::nib_of(snap_q.spd[2])};
      end
      5'd3: wr.val = ipt_pkg::RegNibLo;
      5'd4: begin
        wr.to_data = 1'b1;
        wr.val     = {ipt_pkg::nib_of(snap_q.spd[1]), ipt_pkg::nib_of(snap_q.spd[0])};
      end
      5'd5: wr.val = ipt_pkg::RegPacked;
      5'd6: begin
        wr.to_data = 1'b1;
        wr.val     = {ipt_pkg::two_of(snap_q.spd[3]), ipt_pkg::two_of(snap_q.spd[2]),
                      ipt_pkg::two_of(snap_q.spd[1]), ipt_pkg::two_of(snap_q.spd[0])};
      end
      LastStep: begin
        wr.last = 1'b1;
        wr.val  = ipt_pkg::KeyLock;
      end
      default: begin
        if (off[0]) begin
          wr.to_data = 1'b1;
          wr.val     = ipt_pkg::byte_of(snap_q.spd[drv]);
        end else begin
          wr.val = (off[1] ? ipt_pkg::RegByteB : ipt_pkg::RegByteA) + {6'd0, drv};
        end
      end
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (out_load) begin
      out_valid_d = 1'b1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
    if (snap_load) begin
      busy_d = 1'b1;
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_load) snap_q <= snap_i;
    if (out_load)  out_q  <= wr;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= LastStep)
    else $error("sequencer step past the last write");

  a_last_is_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last |-> !out_q.to_data && out_q.val == ipt_pkg::KeyLock)
    else $error("last write is not the lock key");

  a_first_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_load |=> busy_q && step_q == '0)
    else $error("sequence did not restart at the unlock key");

endmodule
`default_nettype wire
